// File: rtl/mtf_pkg.sv
// Shared types, constants and helpers for the minimum-tracking FIFO.
`default_nettype none
package mtf_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int PTR_W       = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

	localparam logic [1:0] MODE_PUSH  = 2'd0;
	localparam logic [1:0] MODE_POP   = 2'd1;
	localparam logic [1:0] MODE_QUERY = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [7:0] val;
		logic [7:0] mn;
	} entry_t;

	function automatic logic [7:0] min8(input logic [7:0] a, input logic [7:0] b);
		return (a < b) ? a : b;
	endfunction

endpackage
`default_nettype wire

// File: rtl/mtf_ram.sv
// Simple dual-port RAM, one write and one registered read port.
`default_nettype none
module mtf_ram #(
	parameter int DEPTH  = 16,
	parameter int DATA_W = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [DATA_W-1:0]        wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// File: rtl/min_tracking_fifo.sv
// Minimum-tracking FIFO built from two stacks held in RAM.
//
// Input stream: s_tuser carries the operation (push, pop, query minimum),
// s_tdata the value to push. Output stream: m_tdata carries the popped value
// or the minimum, m_tuser the status (ok, empty, full). Every input word
// yields exactly one output word.
//
// Each stack lives in a 16-entry RAM with a registered read port; an entry
// holds a value and the running minimum down to the stack bottom.
// Push, query and a pop that finds the outbound stack occupied first read
// the stack tops, then form the result and update the stack; a push writes
// its entry back. A pop onto an empty outbound stack first moves the inbound
// stack over, one entry per cycle.
//
// A finished result sits in the output register; the next word is taken
// while it waits. If the receiver still stalls when the following result is
// ready, that result is parked and input is held off until it drains.
// Reset empties both stacks and the output register; RAM contents are left.
`default_nettype none
module min_tracking_fifo
	import mtf_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,  // value
	input  wire logic [1:0] s_tuser,  // mode
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic      [7:0] m_tdata,  // data
	output logic      [1:0] m_tuser   // status
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_MOVE = 2'd2;
	localparam logic [1:0] S_RESP = 2'd3;

	logic [1:0]       state_q;
	logic [1:0]       mode_q;
	logic [7:0]       value_q;
	logic [CNT_W-1:0] in_cnt_q;
	logic [CNT_W-1:0] out_cnt_q;
	logic             mv_pend_q;
	logic [7:0]       run_min_q;
	logic [7:0]       last_val_q;
	logic [7:0]       pend_data_q;
	logic [1:0]       pend_status_q;
	logic             m_tvalid_q;
	logic [7:0]       m_data_q;
	logic [1:0]       m_status_q;

	entry_t           in_rdata;
	entry_t           out_rdata;
	entry_t           in_wdata;
	entry_t           out_wdata;
	logic             in_we;
	logic             out_we;
	logic [CNT_W-1:0] in_dec;
	logic [CNT_W-1:0] out_dec;
	logic             res_fire;
	logic [7:0]       res_data;
	logic [1:0]       res_status;
	logic             out_free;
	logic             in_full;

	assign in_dec   = in_cnt_q - CNT_W'(1);
	assign out_dec  = out_cnt_q - CNT_W'(1);
	assign in_full  = (in_cnt_q == CNT_W'(STACK_DEPTH));
	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_status_q;

	mtf_ram #(.DEPTH(STACK_DEPTH), .DATA_W($bits(entry_t))) u_in_ram (
		.clk   (clk),
		.we    (in_we),
		.waddr (in_cnt_q[PTR_W-1:0]),
		.wdata (in_wdata),
		.raddr (in_dec[PTR_W-1:0]),
		.rdata (in_rdata)
	);

	mtf_ram #(.DEPTH(STACK_DEPTH), .DATA_W($bits(entry_t))) u_out_ram (
		.clk   (clk),
		.we    (out_we),
		.waddr (out_cnt_q[PTR_W-1:0]),
		.wdata (out_wdata),
		.raddr (out_dec[PTR_W-1:0]),
		.rdata (out_rdata)
	);

	always_comb begin
		res_fire   = 1'b0;
		res_data   = '0;
		res_status = ST_OK;
		in_we      = 1'b0;
		in_wdata   = '0;
		out_we     = 1'b0;
		out_wdata  = '0;
		case (state_q)
			S_EXEC: begin
				case (mode_q)
					MODE_PUSH: begin
						res_fire     = 1'b1;
						in_wdata.val = value_q;
						in_wdata.mn  = (in_cnt_q != '0) ? min8(value_q, in_rdata.mn)
						                                : value_q;
						if (in_full) begin
							res_status = ST_FULL;
						end else begin
							in_we = 1'b1;
						end
					end
					MODE_POP: begin
						if (out_cnt_q != '0) begin
							res_fire = 1'b1;
							res_data = out_rdata.val;
						end else if (in_cnt_q == '0) begin
							res_fire   = 1'b1;
							res_status = ST_EMPTY;
						end
					end
					MODE_QUERY: begin
						res_fire = 1'b1;
						if (in_cnt_q == '0 && out_cnt_q == '0) begin
							res_status = ST_EMPTY;
						end else if (in_cnt_q == '0) begin
							res_data = out_rdata.mn;
						end else if (out_cnt_q == '0) begin
							res_data = in_rdata.mn;
						end else begin
							res_data = min8(in_rdata.mn, out_rdata.mn);
						end
					end
					default: begin
						res_fire = 1'b1;
					end
				endcase
			end
			S_MOVE: begin
				if (mv_pend_q) begin
					out_we        = 1'b1;
					out_wdata.val = in_rdata.val;
					out_wdata.mn  = (out_cnt_q != '0) ? min8(in_rdata.val, run_min_q)
					                                  : in_rdata.val;
				end
				if (in_cnt_q == '0 && !mv_pend_q) begin
					res_fire = 1'b1;
					res_data = last_val_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			in_cnt_q   <= '0;
			out_cnt_q  <= '0;
			mv_pend_q  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (in_we) begin
						in_cnt_q <= in_cnt_q + CNT_W'(1);
					end
					if (mode_q == MODE_POP && out_cnt_q != '0) begin
						out_cnt_q <= out_dec;
					end
					if (!res_fire) begin
						state_q   <= S_MOVE;
						mv_pend_q <= 1'b0;
					end
				end
				S_MOVE: begin
					if (in_cnt_q != '0) begin
						in_cnt_q  <= in_dec;
						mv_pend_q <= 1'b1;
					end else begin
						mv_pend_q <= 1'b0;
					end
					if (out_we) begin
						out_cnt_q <= out_cnt_q + CNT_W'(1);
					end
					if (res_fire) begin
						out_cnt_q <= out_dec;
					end
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (res_fire) begin
				state_q <= out_free ? S_IDLE : S_RESP;
			end
			if (res_fire && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (state_q == S_RESP && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mode_q  <= s_tuser;
			value_q <= s_tdata;
		end
		if (out_we) begin
			run_min_q  <= out_wdata.mn;
			last_val_q <= out_wdata.val;
		end
		if (res_fire && !out_free) begin
			pend_data_q   <= res_data;
			pend_status_q <= res_status;
		end
		if (res_fire && out_free) begin
			m_data_q   <= res_data;
			m_status_q <= res_status;
		end else if (state_q == S_RESP && out_free) begin
			m_data_q   <= pend_data_q;
			m_status_q <= pend_status_q;
		end
	end

endmodule
`default_nettype wire

// File: rtl/mtf_checker.sv
// Port-level checker for the minimum-tracking FIFO, with its bind.
`default_nettype none
module mtf_port_checker
	import mtf_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_tvalid,
	input wire logic       s_tready,
	input wire logic [7:0] s_tdata,
	input wire logic [1:0] s_tuser,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata,
	input wire logic [1:0] m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output word changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while previous word still in work");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_EMPTY || m_tuser == ST_FULL) |-> m_tdata == 8'd0)
		else $error("error status with non-zero data");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_EMPTY || m_tuser == ST_FULL))
		else $error("undefined status code");

	a_full_only_push: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser != MODE_PUSH |=> ##1 !(m_tvalid && m_tuser == ST_FULL
			&& $rose(m_tvalid)))
		else $error("full status for a word that was not a push");

endmodule

bind min_tracking_fifo mtf_port_checker u_mtf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire
